// File: rtl/u8dw_pkg.sv
`timescale 1ns / 1ps

package u8dw_pkg;

    // Result width, fixed by the output port
    localparam int unsigned OUT_BITS = 16;

    // Defaults handed down from the top level
    localparam int unsigned TOTAL_BITS_DEF  = 16;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Column increment of one request: never more than two columns
    localparam int unsigned DELTA_BITS = 2;

    // One queue entry: columns to add, and whether the string ends here
    typedef struct packed {
        logic [DELTA_BITS-1:0] delta;
        logic                  last;
    } width_entry_t;

    // Queue occupancy as seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Decoder status, for checking
    typedef struct packed {
        logic seq_open;
    } front_status_t;

endpackage

// File: rtl/u8dw_front.sv
`timescale 1ns / 1ps

module u8dw_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            text_byte,
    input  logic                  byte_present,
    input  logic                  end_of_text,
    output u8dw_pkg::width_entry_t entry,
    output u8dw_pkg::front_status_t status
);
    import u8dw_pkg::*;

    typedef enum logic [2:0] {
        BYTE_ASCII,
        BYTE_LEAD2,
        BYTE_LEAD3,
        BYTE_LEAD4,
        BYTE_STRAY
    } byte_class_t;

    function automatic byte_class_t classify_byte(input logic [7:0] b);
        byte_class_t k;
        priority if (b[7] == 1'b0)       k = BYTE_ASCII;
        else if (b[7:5] == 3'b110)       k = BYTE_LEAD2;
        else if (b[7:4] == 4'b1110)      k = BYTE_LEAD3;
        else if (b[7:3] == 5'b11110)     k = BYTE_LEAD4;
        else                             k = BYTE_STRAY;
        return k;
    endfunction

    function automatic logic in_rng(input logic [20:0] c, input logic [20:0] lo,
                                    input logic [20:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic [DELTA_BITS-1:0] columns_of(input logic [20:0] c);
        logic ctrl;
        logic comb;
        logic wide;
        ctrl = (c < 21'h20) || in_rng(c, 21'h7f, 21'h9f);
        comb = in_rng(c, 21'h0300, 21'h036f) || in_rng(c, 21'h1ab0, 21'h1aff) ||
               in_rng(c, 21'h1dc0, 21'h1dff) || in_rng(c, 21'h20d0, 21'h20ff) ||
               in_rng(c, 21'hfe20, 21'hfe2f);
        wide = in_rng(c, 21'h1100, 21'h115f) || (c == 21'h2329) || (c == 21'h232a) ||
               (in_rng(c, 21'h2e80, 21'ha4cf) && (c != 21'h303f)) ||
               in_rng(c, 21'hac00, 21'hd7a3) || in_rng(c, 21'hf900, 21'hfaff) ||
               in_rng(c, 21'hfe10, 21'hfe19) || in_rng(c, 21'hfe30, 21'hfe6f) ||
               in_rng(c, 21'hff00, 21'hff60) || in_rng(c, 21'hffe0, 21'hffe6) ||
               in_rng(c, 21'h1f300, 21'h1f64f) || in_rng(c, 21'h1f900, 21'h1f9ff) ||
               in_rng(c, 21'h20000, 21'h3fffd);
        if (ctrl || comb)
            return DELTA_BITS'(0);
        else if (wide)
            return DELTA_BITS'(2);
        else
            return DELTA_BITS'(1);
    endfunction

    logic [7:0]  lead_reg,    lead_next;
    logic [20:0] partial_reg, partial_next;
    logic [1:0]  remain_reg,  remain_next;

    logic                  restart;
    logic [20:0]           shifted;
    logic [DELTA_BITS-1:0] term_broken;
    logic [DELTA_BITS-1:0] term_start;
    logic [DELTA_BITS-1:0] term_tail;

    always_comb
    begin
        lead_next    = lead_reg;
        partial_next = partial_reg;
        remain_next  = remain_reg;
        restart      = 1'b0;
        term_broken  = '0;
        term_start   = '0;
        term_tail    = '0;
        shifted      = {partial_reg[14:0], text_byte[5:0]};

        if (byte_present) begin
            if (remain_reg != 2'd0) begin
                if (text_byte[7:6] == 2'b10) begin
                    partial_next = shifted;
                    remain_next  = remain_reg - 2'd1;
                    if (remain_reg == 2'd1)
                        term_start = columns_of(shifted);
                end else begin
                    // broken sequence: lead counts alone, breaker decoded afresh
                    term_broken = columns_of({13'd0, lead_reg});
                    remain_next = 2'd0;
                    restart     = 1'b1;
                end
            end else begin
                restart = 1'b1;
            end
        end

        if (restart) begin
            unique case (classify_byte(text_byte))
                BYTE_LEAD2: begin
                    lead_next    = text_byte;
                    partial_next = {16'd0, text_byte[4:0]};
                    remain_next  = 2'd1;
                end
                BYTE_LEAD3: begin
                    lead_next    = text_byte;
                    partial_next = {17'd0, text_byte[3:0]};
                    remain_next  = 2'd2;
                end
                BYTE_LEAD4: begin
                    lead_next    = text_byte;
                    partial_next = {18'd0, text_byte[2:0]};
                    remain_next  = 2'd3;
                end
                default: term_start = columns_of({13'd0, text_byte});
            endcase
        end

        if (end_of_text) begin
            if (remain_next != 2'd0)
                term_tail = columns_of({13'd0, lead_next});
            lead_next    = '0;
            partial_next = '0;
            remain_next  = 2'd0;
        end
    end

    // at most two columns per request in every case
    assign entry.delta     = term_broken + term_start + term_tail;
    assign entry.last      = end_of_text;
    assign status.seq_open = (remain_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lead_reg    <= '0;
            partial_reg <= '0;
            remain_reg  <= '0;
        end else if (fire) begin
            lead_reg    <= lead_next;
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// File: rtl/u8dw_queue.sv
`timescale 1ns / 1ps

module u8dw_queue #(
    parameter int unsigned QUEUE_DEPTH = u8dw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  u8dw_pkg::width_entry_t wr_entry,
    input  logic                   pop,
    output u8dw_pkg::width_entry_t head,
    output u8dw_pkg::queue_status_t status
);
    import u8dw_pkg::*;

    localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    width_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg,  count_next;
    logic                 do_push;
    logic                 do_pop;

    assign status.full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/u8dw_back.sv
`timescale 1ns / 1ps

module u8dw_back #(
    parameter int unsigned TOTAL_BITS = u8dw_pkg::TOTAL_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  u8dw_pkg::width_entry_t      head,
    input  u8dw_pkg::queue_status_t     q_status,
    output logic                        pop,
    output logic [u8dw_pkg::OUT_BITS-1:0] column_width,
    output logic                        out_valid,
    input  logic                        out_ready
);
    import u8dw_pkg::*;

    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0] sat;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   result_reg;

    // a closing request waits until the output slot is free
    assign pop = !q_status.empty && (!head.last || !out_valid_reg || out_ready);

    assign sum = {1'b0, total_reg} + (TOTAL_BITS + 1)'(head.delta);
    assign sat = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];

    always_comb
    begin
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop) begin
            if (head.last) begin
                total_next     = '0;
                out_valid_next = 1'b1;
            end else begin
                total_next = sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
            result_reg <= OUT_BITS'(sat);
    end

    assign out_valid    = out_valid_reg;
    assign column_width = result_reg;

endmodule

// File: rtl/utf8_display_width_counter.sv
`timescale 1ns / 1ps

// utf8_display_width_counter: terminal column count of a UTF-8 string.
//
// Input channel (in_valid/in_ready): one request per string byte; text_byte is
// used when byte_present is high; end_of_text marks the last request, which may
// carry no byte. Output channel (out_valid/out_ready): one request per string,
// column_width = total columns, saturated at 2^TOTAL_BITS-1, low 16 bits shown.
//
// Structure: the front decodes UTF-8 and classifies each request into a column
// increment of 0..2 in the cycle it is taken; a QUEUE_DEPTH-entry queue sits
// between it and the back, which accumulates and holds the result register.
// Throughput: one byte per cycle, sustained, while the output is drained.
// Result path: with the queue empty, the end_of_text request is written into the queue
// when it is taken, then popped by the back, which loads the result register and out_valid.
// Stall: while out_ready is low the back holds the result and keeps summing
// the next string until its own end arrives; the queue then fills and
// in_ready drops once QUEUE_DEPTH requests are waiting.
// Reset: decoder, running total, queue and output valid all clear at once;
// the block is ready for requests as soon as reset is released.

module utf8_display_width_counter #(
    parameter int unsigned TOTAL_BITS  = u8dw_pkg::TOTAL_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = u8dw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    text_byte,
    input  logic                          byte_present,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8dw_pkg::OUT_BITS-1:0] column_width
);
    import u8dw_pkg::*;

    width_entry_t  front_entry;
    width_entry_t  q_head;
    queue_status_t q_status;
    front_status_t f_status;
    logic          in_fire;
    logic          q_pop;

    // take a byte whenever the queue has room
    assign in_ready = !q_status.full;
    assign in_fire  = in_valid && in_ready;

    // front: UTF-8 decode and width classification
    u8dw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (in_fire),
        .text_byte    (text_byte),
        .byte_present (byte_present),
        .end_of_text  (end_of_text),
        .entry        (front_entry),
        .status       (f_status)
    );

    // short queue decoupling front from accumulator
    u8dw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_fire),
        .wr_entry (front_entry),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    // back: saturating accumulator and result register
    u8dw_back #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_status     (q_status),
        .pop          (q_pop),
        .column_width (column_width),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    // a closing request leaves the decoder with no open sequence
    a_close_clears_decoder: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_text |=> !f_status.seq_open)
        else $error("decoder sequence still open after end of text");

    // never pop an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // a result is never written over one still waiting
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_head.last |-> !out_valid || out_ready)
        else $error("pending result overwritten");

endmodule
